FILE: sv/rdq_pkg.sv
// Shared types and codes for the ring deque with search.
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

   // Request kinds as they arrive on the request channel.
   localparam logic [2:0] KIND_PUSH     = 3'd0;
   localparam logic [2:0] KIND_POP_NEW  = 3'd1;
   localparam logic [2:0] KIND_POP_OLD  = 3'd2;
   localparam logic [2:0] KIND_FIND     = 3'd3;
   localparam logic [2:0] KIND_REMOVE   = 3'd4;
   localparam logic [2:0] KIND_READ     = 3'd5;

   // Response status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   // Operation after classification by the front end.
   typedef enum logic [2:0] {
      OP_PUSH    = 3'd0,
      OP_POP_NEW = 3'd1,
      OP_POP_OLD = 3'd2,
      OP_FIND    = 3'd3,
      OP_REMOVE  = 3'd4,
      OP_READ    = 3'd5,
      OP_BAD     = 3'd6
   } op_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [3:0]  index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_res;
      logic [3:0]  found_index;
      logic [4:0]  count;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic [3:0]  index;
   } cmd_type;

endpackage

`default_nettype wire

FILE: sv/rdq_front.sv
// Front end: accept requests, classify them, and queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rdq_front
   import rdq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         q_valid,
   output cmd_type      q_cmd,
   input  wire logic    q_pop
);

   cmd_type    cmd_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   // Decode the kind; unused codes fall through as a bad request.
   always_comb begin
      cmd_in.value = req_data.value;
      cmd_in.index = req_data.index;
      case (req_data.kind)
         KIND_PUSH:    cmd_in.op = OP_PUSH;
         KIND_POP_NEW: cmd_in.op = OP_POP_NEW;
         KIND_POP_OLD: cmd_in.op = OP_POP_OLD;
         KIND_FIND:    cmd_in.op = OP_FIND;
         KIND_REMOVE:  cmd_in.op = OP_REMOVE;
         KIND_READ:    cmd_in.op = OP_READ;
         default:      cmd_in.op = OP_BAD;
      endcase
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = cmd_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rdq_back.sv
// Back end: entry memory, head and occupancy, sequencer and response register.
`timescale 1ns / 1ps
`default_nettype none

module rdq_back
   import rdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int IW = (CW > 4) ? CW : 4;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] value_ff, value_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] entry_mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_data;

   logic [AW-1:0] head_prev;
   logic [AW-1:0] head_next;
   logic [CW-1:0] occ_dec;
   logic [CW-1:0] idx_c;
   logic          idx_ok;

   // Physical slot of a position counted from the newest entry.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(p);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign occ_dec   = occ_ff - 1'b1;
   assign idx_c     = CW'(q_cmd.index);
   assign idx_ok    = IW'(q_cmd.index) < IW'(occ_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      fidx_in      = fidx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_prev;
      wr_data      = q_cmd.value;
      q_pop        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            status_in = ST_OK;
            value_in  = '0;
            fidx_in   = '0;
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = S_RESULT;
               case (q_cmd.op)
                  OP_PUSH: begin
                     if (occ_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        head_in = head_prev;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_POP_NEW: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        head_in  = head_next;
                        occ_in   = occ_dec;
                        state_in = S_READ;
                     end
                  end
                  OP_POP_OLD: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr  = slot_of(head_ff, occ_dec);
                        occ_in   = occ_dec;
                        state_in = S_READ;
                     end
                  end
                  OP_READ: begin
                     if (!idx_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        rd_addr  = slot_of(head_ff, idx_c);
                        state_in = S_READ;
                     end
                  end
                  OP_FIND: begin
                     if (occ_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        pos_in   = '0;
                        word_in  = q_cmd.value;
                        rd_addr  = slot_of(head_ff, '0);
                        state_in = S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     if (!idx_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        occ_in = occ_dec;
                        // Removing the oldest entry leaves nothing to shift.
                        if (idx_c != occ_dec) begin
                           pos_in   = idx_c;
                           rd_addr  = slot_of(head_ff, idx_c + 1'b1);
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_READ: begin
            value_in = rd_data_ff;
            state_in = S_RESULT;
         end
         S_SCAN: begin
            if (rd_data_ff == word_ff) begin
               fidx_in  = 4'(pos_ff);
               state_in = S_RESULT;
            end else if (pos_ff + 1'b1 == occ_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESULT;
            end else begin
               pos_in  = pos_ff + 1'b1;
               rd_addr = slot_of(head_ff, pos_ff + 1'b1);
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, pos_ff);
            wr_data = rd_data_ff;
            if (pos_ff + 1'b1 == occ_ff) begin
               state_in = S_RESULT;
            end else begin
               pos_in  = pos_ff + 1'b1;
               rd_addr = slot_of(head_ff, pos_ff + CW'(2));
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.value_res   = value_ff;
               rsp_data_in.found_index = fidx_ff;
               rsp_data_in.count       = 5'(occ_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
      fidx_ff     <= fidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sv/ring_deque_with_search_top.sv
// Top level of the ring deque with search: front end, command queue, back end.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------------
//   req_     | in        | req_valid/req_stall | kind, value, index (req_type)
//   rsp_     | out       | rsp_valid/rsp_stall | status, value_res, found_index, count
//
// Sequencing: one request is in flight in the back end at a time. Push and
// bad requests go from idle to the result state, pops and reads pass a read
// state first, find compares one entry per step while scanning and remove
// moves one entry per step while shifting, over the single memory read port.
// Reset: synchronous, active high; clears head, count, queue and response
// valid. Entry contents are not cleared and need no clearing pass.
// Stalls: the front queue keeps taking requests while the back end waits on
// rsp_stall, until its two entries are full, and the response register holds
// a finished result while the back end starts the next request.
`timescale 1ns / 1ps
`default_nettype none

module ring_deque_with_search_top
   import rdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Command queue between the front and the back end.
   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;

   // Accept and classify requests; hold up to two decoded commands.
   rdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   // Carry out one command at a time against the entry memory.
   rdq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: sv/rdq_checker.sv
// Port-level checks on the ring deque with search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rdq_checker
   import rdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Hold a stalled request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // Hold a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A full status reports a full count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == 5'(DEPTH))
      else $error("full status with wrong count");

   // An empty status reports a zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.count == 5'd0)
      else $error("empty status with nonzero count");

   // A failed request returns no word and no position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.value_res == 32'd0 && rsp_data.found_index == 4'd0)
      else $error("failed request carries data");

endmodule

bind ring_deque_with_search_top rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (.*);

`default_nettype wire
